>>> sv/skun_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Search key normaliser package
// Beat types, code point constants and the normalise/encode functions.
// ----------------------------------------------------------------------------
package skun_pkg;

	localparam logic [20:0] CP_REPL       = 21'h00FFFD;
	localparam logic [20:0] CP_UPPER_A    = 21'h000041;
	localparam logic [20:0] CP_UPPER_Z    = 21'h00005A;
	localparam logic [20:0] CP_HYPHEN     = 21'h00002D;
	localparam logic [20:0] CP_APOS       = 21'h000027;
	localparam logic [20:0] CP_SPACE      = 21'h000020;
	localparam logic [20:0] CP_IDEO_COMMA = 21'h003001;
	localparam logic [20:0] CP_IDEO_STOP  = 21'h003002;
	localparam logic [20:0] CP_WAVE_DASH  = 21'h00301C;
	localparam logic [20:0] CP_KANA_LO    = 21'h0030A0;
	localparam logic [20:0] CP_KANA_HI    = 21'h0030FF;
	localparam logic [20:0] CP_WIDE_LO    = 21'h00FF00;
	localparam logic [20:0] CP_WIDE_HI    = 21'h00FF9F;
	localparam logic [20:0] CP_CASE_GAP   = 21'h000020;

	localparam logic [7:0] REPL_B0 = 8'hEF;
	localparam logic [7:0] REPL_B1 = 8'hBF;
	localparam logic [7:0] REPL_B2 = 8'hBD;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       end_of_text;
	} text_beat_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       byte_valid;
		logic       final_result;
	} key_beat_t;

	typedef struct packed {
		logic        rep;
		logic        cp_valid;
		logic [20:0] cp;
		logic        last;
	} cmd_t;

	typedef struct packed {
		logic        keep;
		logic [20:0] cp;
	} norm_t;

	typedef struct packed {
		logic [3:0][7:0] b;
		logic [2:0]      n;
	} enc_t;

	function automatic logic [15:0] kana_fold(input logic [6:0] idx);
		logic [15:0] m;
		case (idx)
			7'd1:  m = 16'h30A2;
			7'd3:  m = 16'h30A4;
			7'd5:  m = 16'h30A6;
			7'd7:  m = 16'h30A8;
			7'd9:  m = 16'h30AA;
			7'd12: m = 16'h30AB;
			7'd14: m = 16'h30AD;
			7'd16: m = 16'h30AF;
			7'd18: m = 16'h30B1;
			7'd20: m = 16'h30B3;
			7'd22: m = 16'h30B5;
			7'd24: m = 16'h30B7;
			7'd26: m = 16'h30B9;
			7'd28: m = 16'h30BB;
			7'd30: m = 16'h30BD;
			7'd32: m = 16'h30BF;
			7'd34: m = 16'h30C1;
			7'd35: m = 16'h30C4;
			7'd37: m = 16'h30C4;
			7'd39: m = 16'h30C6;
			7'd41: m = 16'h30C8;
			7'd48: m = 16'h30CF;
			7'd49: m = 16'h30CF;
			7'd51: m = 16'h30D2;
			7'd52: m = 16'h30D2;
			7'd54: m = 16'h30D5;
			7'd55: m = 16'h30D5;
			7'd57: m = 16'h30D8;
			7'd58: m = 16'h30D8;
			7'd60: m = 16'h30DB;
			7'd61: m = 16'h30DB;
			7'd67: m = 16'h30E4;
			7'd69: m = 16'h30E6;
			7'd71: m = 16'h30E8;
			7'd78: m = 16'h30EF;
			7'd84: m = 16'h30A6;
			7'd85: m = 16'h30AB;
			7'd86: m = 16'h30B1;
			7'd87: m = 16'h30EF;
			7'd88: m = 16'h30F0;
			7'd89: m = 16'h30F1;
			7'd90: m = 16'h30F2;
			default: m = 16'h0000;
		endcase
		return m;
	endfunction

	function automatic norm_t normalise(input logic [20:0] cp);
		norm_t       r;
		logic [15:0] m;
		logic [20:0] off;
		r.keep = 1'b1;
		r.cp   = cp;
		off    = cp - CP_KANA_LO;
		m      = kana_fold(off[6:0]);
		if (cp >= CP_UPPER_A && cp <= CP_UPPER_Z) begin
			r.cp = cp + CP_CASE_GAP;
		end else if (cp == CP_HYPHEN) begin
			r.cp = CP_SPACE;
		end else if (cp == CP_APOS) begin
			r.keep = 1'b0;
		end else if (cp == CP_IDEO_COMMA) begin
			r.cp = 21'h00002C;
		end else if (cp == CP_IDEO_STOP) begin
			r.cp = 21'h00002E;
		end else if (cp == CP_WAVE_DASH) begin
			r.cp = 21'h00007E;
		end else if (cp >= CP_KANA_LO && cp <= CP_KANA_HI) begin
			if (m != 16'h0000) begin
				r.cp = {5'b0, m};
			end
		end else if (cp >= CP_WIDE_LO && cp <= CP_WIDE_HI) begin
			r.cp = cp - CP_WIDE_LO + CP_SPACE;
		end
		return r;
	endfunction

	function automatic enc_t encode(input logic [20:0] cp);
		enc_t e;
		e.b = '0;
		if (cp < 21'h000080) begin
			e.b[0] = cp[7:0];
			e.n    = 3'd1;
		end else if (cp < 21'h000800) begin
			e.b[0] = {3'b110, cp[10:6]};
			e.b[1] = {2'b10, cp[5:0]};
			e.n    = 3'd2;
		end else if (cp < 21'h010000) begin
			e.b[0] = {4'b1110, cp[15:12]};
			e.b[1] = {2'b10, cp[11:6]};
			e.b[2] = {2'b10, cp[5:0]};
			e.n    = 3'd3;
		end else begin
			e.b[0] = {5'b11110, cp[20:18]};
			e.b[1] = {2'b10, cp[17:12]};
			e.b[2] = {2'b10, cp[11:6]};
			e.b[3] = {2'b10, cp[5:0]};
			e.n    = 3'd4;
		end
		return e;
	endfunction

endpackage
`default_nettype wire

>>> sv/skun_text_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Source text channel
// Valid/ready channel carrying one UTF-8 source byte per beat.
// ----------------------------------------------------------------------------
interface skun_text_if
	import skun_pkg::*;
	();
	logic       valid;
	logic       ready;
	text_beat_t payload;

	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);
endinterface
`default_nettype wire

>>> sv/skun_key_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Normalised key channel
// Valid/ready channel carrying one normalised byte or end marker per beat.
// ----------------------------------------------------------------------------
interface skun_key_if
	import skun_pkg::*;
	();
	logic      valid;
	logic      ready;
	key_beat_t payload;

	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);
endinterface
`default_nettype wire

>>> sv/skun_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Normaliser front end
// Decodes UTF-8 beats to code points and queues a command for each beat that
// completes a code point, is malformed or ends the text.
module skun_front
	import skun_pkg::*;
(
	input  wire logic   clk,
	input  wire logic   arst_n,
	skun_text_if.sink   text,
	input  wire logic   full,
	output logic        push,
	output cmd_t        cmd
);

	logic [1:0]  cl_q;
	logic [20:0] part_q;

	logic [7:0]  b;
	logic        e;
	logic        acc;
	logic        st_emit, st_bad;
	logic [1:0]  st_cl;
	logic [20:0] st_part;
	logic [7:0]  lo, hi;
	logic [20:0] joined;
	logic        rep, bad, cpv;
	logic [1:0]  nxt_cl;
	logic [20:0] nxt_part;

	assign b          = text.payload.in_byte;
	assign e          = text.payload.end_of_text;
	assign text.ready = !full;
	assign acc        = text.valid && !full;
	assign joined     = {part_q[14:0], b[5:0]};

	always_comb begin
		st_emit = !b[7];
		st_bad  = 1'b0;
		st_cl   = 2'd0;
		st_part = '0;
		if (b[7]) begin
			if (b < 8'hC2) begin
				st_bad = 1'b1;
			end else if (b < 8'hE0) begin
				st_part = {16'b0, b[4:0]};
				st_cl   = 2'd1;
			end else if (b < 8'hF0) begin
				st_part = {17'b0, b[3:0]};
				st_cl   = 2'd2;
			end else if (b < 8'hF5) begin
				st_part = {18'b0, b[2:0]};
				st_cl   = 2'd3;
			end else begin
				st_bad = 1'b1;
			end
		end
	end

	always_comb begin
		lo = 8'h80;
		hi = 8'hBF;
		if (cl_q == 2'd3) begin
			if (part_q == 21'd0) begin
				lo = 8'h90;
			end else if (part_q == 21'd4) begin
				hi = 8'h8F;
			end
		end else if (cl_q == 2'd2 && part_q < 21'h10) begin
			if (part_q == 21'd0) begin
				lo = 8'hA0;
			end else if (part_q == 21'hD) begin
				hi = 8'h9F;
			end
		end
	end

	always_comb begin
		rep      = 1'b0;
		bad      = 1'b0;
		cpv      = 1'b0;
		cmd.cp   = {13'b0, b};
		nxt_cl   = cl_q;
		nxt_part = part_q;
		if (cl_q != 2'd0) begin
			if (b >= lo && b <= hi) begin
				nxt_cl = cl_q - 2'd1;
				if (cl_q == 2'd1) begin
					cpv      = 1'b1;
					cmd.cp   = joined;
					nxt_part = '0;
				end else begin
					nxt_part = joined;
				end
			end else if (b < 8'h80 || b > 8'hBF) begin
				rep      = 1'b1;
				cpv      = st_emit;
				nxt_cl   = st_cl;
				nxt_part = st_part;
			end else begin
				bad      = 1'b1;
				nxt_cl   = 2'd0;
				nxt_part = '0;
			end
		end else begin
			cpv      = st_emit;
			bad      = st_bad;
			nxt_cl   = st_cl;
			nxt_part = st_part;
		end
		if (e) begin
			if (nxt_cl != 2'd0 && !rep) begin
				bad = 1'b1;
			end
			nxt_cl   = 2'd0;
			nxt_part = '0;
		end
		cmd.rep      = rep || bad;
		cmd.cp_valid = cpv;
		cmd.last     = e;
		push         = acc && (rep || bad || cpv || e);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cl_q   <= 2'd0;
			part_q <= '0;
		end else if (acc) begin
			cl_q   <= nxt_cl;
			part_q <= nxt_part;
		end
	end

endmodule
`default_nettype wire

>>> sv/skun_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Command queue
// Short FIFO of decoded commands between the front and back ends.
// ----------------------------------------------------------------------------
module skun_queue
	import skun_pkg::*;
#(
	parameter int DEPTH = 4
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  wire cmd_t push_cmd,
	output logic      full,
	input  wire logic pop,
	output cmd_t      head,
	output logic      head_valid
);

	localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CntW = $clog2(DEPTH + 1);

	cmd_t            slot_q [DEPTH];
	logic [PtrW-1:0] wr_q, rd_q;
	logic [CntW-1:0] count_q;

	assign full       = (count_q == CntW'(DEPTH));
	assign head_valid = (count_q != '0);
	assign head       = slot_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PtrW'(DEPTH - 1)) ? '0 : wr_q + PtrW'(1);
			end
			if (pop) begin
				rd_q <= (rd_q == PtrW'(DEPTH - 1)) ? '0 : rd_q + PtrW'(1);
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + CntW'(1);
				2'b01:   count_q <= count_q - CntW'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !push)
		else $error("queue written while full");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> head_valid)
		else $error("queue read while empty");

endmodule
`default_nettype wire

>>> sv/skun_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Normaliser back end
// Normalises and re-encodes each command, then sends its bytes one per beat.
// ----------------------------------------------------------------------------
module skun_back
	import skun_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire cmd_t  head,
	input  wire logic  head_valid,
	output logic       pop,
	skun_key_if.source key
);

	logic            busy_q;
	logic [1:0]      idx_q;
	logic [3:0][7:0] buf_q;
	logic [2:0]      n_q;
	logic            last_q;
	logic            marker_q;

	norm_t           nrm;
	enc_t            enc;
	logic [3:0][7:0] nb;
	logic [2:0]      nn;
	logic [2:0]      sum;
	logic            is_last_byte;
	logic            take, done, free;

	assign nrm = normalise(head.cp);
	assign enc = encode(nrm.cp);
	assign sum = 3'd3 + enc.n;

	always_comb begin
		nb = enc.b;
		nn = (head.cp_valid && nrm.keep) ? enc.n : 3'd0;
		if (head.rep) begin
			nb[0] = REPL_B0;
			nb[1] = REPL_B1;
			nb[2] = REPL_B2;
			nb[3] = enc.b[0];
			if (head.cp_valid && nrm.keep) begin
				nn = (sum > 3'd4) ? 3'd4 : sum;
			end else begin
				nn = 3'd3;
			end
		end
	end

	assign is_last_byte = ({1'b0, idx_q} == n_q - 3'd1);
	assign take         = busy_q && key.ready;
	assign done         = take && is_last_byte;
	assign free         = !busy_q || done;
	assign pop          = head_valid && free;

	assign key.valid                = busy_q;
	assign key.payload.out_byte     = marker_q ? 8'h00 : buf_q[idx_q];
	assign key.payload.byte_valid   = !marker_q;
	assign key.payload.final_result = last_q && is_last_byte;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= 2'd0;
		end else if (pop) begin
			busy_q <= (nn != 3'd0) || head.last;
			idx_q  <= 2'd0;
		end else if (done) begin
			busy_q <= 1'b0;
		end else if (take) begin
			idx_q <= idx_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			buf_q    <= nb;
			last_q   <= head.last;
			marker_q <= (nn == 3'd0);
			n_q      <= (nn == 3'd0) ? 3'd1 : nn;
		end
	end

	a_idx_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> ({1'b0, idx_q} < n_q))
		else $error("byte index beyond loaded count");

	a_marker_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(busy_q && marker_q) |-> (last_q && n_q == 3'd1))
		else $error("bare end marker without end of string");

endmodule
`default_nettype wire

>>> sv/search_key_utf8_normalizer.sv
`timescale 1ns / 1ps
`default_nettype none
// Path: a command is registered in the queue, then in the back end's buffer.
// Throughput: one source byte per cycle in while the queue is not full, one
// output byte per cycle out while the sink is ready; a command holds the byte
// sequencer until its up to 4 beats are sent; the queue absorbs the difference.
// Reset: clears decode state, empties the queue and idles the output; no
// clearing pass.
// ----------------------------------------------------------------------------
// Search key UTF-8 normaliser
// Decode front end, command queue and normalise/encode back end.
// ----------------------------------------------------------------------------
module search_key_utf8_normalizer
	import skun_pkg::*;
#(
	parameter int QUEUE_DEPTH = 4
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	skun_text_if.sink  text,
	skun_key_if.source key
);

	logic push, full, pop, head_valid;
	cmd_t push_cmd, head;

	skun_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.text   (text),
		.full   (full),
		.push   (push),
		.cmd    (push_cmd)
	);

	skun_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_cmd   (push_cmd),
		.full       (full),
		.pop        (pop),
		.head       (head),
		.head_valid (head_valid)
	);

	skun_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head),
		.head_valid (head_valid),
		.pop        (pop),
		.key        (key)
	);

endmodule
`default_nettype wire

>>> dv/search_key_utf8_normalizer_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Search key UTF-8 normaliser testbench
// Feeds strings of UTF-8 bytes through the source channel and checks every
// normalised byte against an in-bench decoder, folder and encoder. Directed
// strings cover the folding rules and the malformed forms; random strings
// mix well-formed text, broken sequences and noise, with random gaps on
// both channels.
// ----------------------------------------------------------------------------
module search_key_utf8_normalizer_tb;
	import skun_pkg::*;

	localparam int TEXT_ITEMS = 270;

	logic clk;
	logic arst_n;

	skun_text_if text_ch ();
	skun_key_if  key_ch ();

	search_key_utf8_normalizer uut (
		.clk   (clk),
		.arst_n(arst_n),
		.text  (text_ch),
		.key   (key_ch)
	);

	logic [15:0] kana_map [0:95] = '{
		16'h0000, 16'h30A2, 16'h0000, 16'h30A4, 16'h0000, 16'h30A6, 16'h0000, 16'h30A8,
		16'h0000, 16'h30AA, 16'h0000, 16'h0000, 16'h30AB, 16'h0000, 16'h30AD, 16'h0000,
		16'h30AF, 16'h0000, 16'h30B1, 16'h0000, 16'h30B3, 16'h0000, 16'h30B5, 16'h0000,
		16'h30B7, 16'h0000, 16'h30B9, 16'h0000, 16'h30BB, 16'h0000, 16'h30BD, 16'h0000,
		16'h30BF, 16'h0000, 16'h30C1, 16'h30C4, 16'h0000, 16'h30C4, 16'h0000, 16'h30C6,
		16'h0000, 16'h30C8, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
		16'h30CF, 16'h30CF, 16'h0000, 16'h30D2, 16'h30D2, 16'h0000, 16'h30D5, 16'h30D5,
		16'h0000, 16'h30D8, 16'h30D8, 16'h0000, 16'h30DB, 16'h30DB, 16'h0000, 16'h0000,
		16'h0000, 16'h0000, 16'h0000, 16'h30E4, 16'h0000, 16'h30E6, 16'h0000, 16'h30E8,
		16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h30EF, 16'h0000,
		16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h30A6, 16'h30AB, 16'h30B1, 16'h30EF,
		16'h30F0, 16'h30F1, 16'h30F2, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000
	};

	logic [20:0] dec_cp;
	logic [1:0]  dec_left;
	logic [7:0]  step_bytes [$];
	key_beat_t   key_expected [$];
	logic [7:0]  text_bytes [$];

	int  mismatches;
	int  items_sent;
	int  sink_hold;
	bit  src_idling;
	bit  snk_idling;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	initial begin
		#2_000_000;
		$display("Simulation FAILED");
		$finish;
	end

	function automatic int idle_gap(input bit en);
		int r;
		r = $urandom_range(0, 99);
		if (!en || r < 65)
			return 0;
		if (r < 93)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	function automatic int utf8_encode(input logic [20:0] cp, output logic [3:0][7:0] enc);
		enc = '0;
		if (cp < 21'h80) begin
			enc[0] = cp[7:0];
			return 1;
		end
		if (cp < 21'h800) begin
			enc[0] = {3'b110, cp[10:6]};
			enc[1] = {2'b10, cp[5:0]};
			return 2;
		end
		if (cp < 21'h10000) begin
			enc[0] = {4'b1110, cp[15:12]};
			enc[1] = {2'b10, cp[11:6]};
			enc[2] = {2'b10, cp[5:0]};
			return 3;
		end
		enc[0] = {5'b11110, cp[20:18]};
		enc[1] = {2'b10, cp[17:12]};
		enc[2] = {2'b10, cp[11:6]};
		enc[3] = {2'b10, cp[5:0]};
		return 4;
	endfunction

	function automatic logic [20:0] fold_code(input logic [20:0] cp);
		logic [20:0] off;
		off = cp - CP_KANA_LO;
		if (cp >= CP_UPPER_A && cp <= CP_UPPER_Z)
			return cp + CP_CASE_GAP;
		if (cp == CP_HYPHEN)
			return CP_SPACE;
		if (cp == CP_IDEO_COMMA)
			return 21'h00002C;
		if (cp == CP_IDEO_STOP)
			return 21'h00002E;
		if (cp == CP_WAVE_DASH)
			return 21'h00007E;
		if (cp >= CP_KANA_LO && cp <= CP_KANA_HI)
			return (kana_map[off[6:0]] != 16'h0000) ? {5'b0, kana_map[off[6:0]]} : cp;
		if (cp >= CP_WIDE_LO && cp <= CP_WIDE_HI)
			return cp - CP_WIDE_LO + CP_SPACE;
		return cp;
	endfunction

	function automatic void emit_code(input logic [20:0] cp);
		logic [3:0][7:0] enc;
		int              n;
		n = utf8_encode(cp, enc);
		for (int i = 0; i < n; i++)
			if (step_bytes.size() < 4)
				step_bytes.push_back(enc[i]);
	endfunction

	function automatic void take_code(input logic [20:0] cp);
		if (cp != CP_APOS)
			emit_code(fold_code(cp));
	endfunction

	// returns 1 for a byte that cannot start a character
	function automatic bit open_sequence(input logic [7:0] b);
		if (b < 8'h80) begin
			take_code({13'd0, b});
			return 1'b0;
		end
		if (b < 8'hC2)
			return 1'b1;
		if (b < 8'hE0) begin
			dec_cp   = {16'd0, b[4:0]};
			dec_left = 2'd1;
			return 1'b0;
		end
		if (b < 8'hF0) begin
			dec_cp   = {17'd0, b[3:0]};
			dec_left = 2'd2;
			return 1'b0;
		end
		if (b < 8'hF5) begin
			dec_cp   = {18'd0, b[2:0]};
			dec_left = 2'd3;
			return 1'b0;
		end
		return 1'b1;
	endfunction

	function automatic void predict_key_bytes(input logic [7:0] b, input logic eot);
		bit          bad;
		bit          have_repl;
		logic [7:0]  lo;
		logic [7:0]  hi;
		logic [20:0] cp;
		key_beat_t   beat;
		step_bytes.delete();
		bad = 1'b0;
		if (dec_left != 2'd0) begin
			lo = 8'h80;
			hi = 8'hBF;
			if (dec_left == 2'd3) begin
				if (dec_cp == 21'd0)
					lo = 8'h90;
				else if (dec_cp == 21'd4)
					hi = 8'h8F;
			end else if (dec_left == 2'd2 && dec_cp < 21'h10) begin
				if (dec_cp == 21'd0)
					lo = 8'hA0;
				else if (dec_cp == 21'hD)
					hi = 8'h9F;
			end
			if (b >= lo && b <= hi) begin
				dec_cp   = {dec_cp[14:0], b[5:0]};
				dec_left = dec_left - 2'd1;
				if (dec_left == 2'd0) begin
					cp     = dec_cp;
					dec_cp = '0;
					take_code(cp);
				end
			end else begin
				bad      = 1'b1;
				dec_left = '0;
				dec_cp   = '0;
				if (b < 8'h80 || b > 8'hBF) begin
					emit_code(CP_REPL);
					void'(open_sequence(b));
					bad = 1'b0;
				end
			end
		end else begin
			bad = open_sequence(b);
		end
		if (eot) begin
			if (dec_left != 2'd0) begin
				have_repl = 1'b0;
				for (int i = 0; i + 2 < step_bytes.size(); i++)
					if (step_bytes[i] == REPL_B0 && step_bytes[i+1] == REPL_B1 &&
					    step_bytes[i+2] == REPL_B2)
						have_repl = 1'b1;
				if (!have_repl)
					bad = 1'b1;
			end
			dec_left = '0;
			dec_cp   = '0;
		end
		if (bad)
			emit_code(CP_REPL);
		if (step_bytes.size() == 0) begin
			if (eot) begin
				beat.out_byte     = 8'h00;
				beat.byte_valid   = 1'b0;
				beat.final_result = 1'b1;
				key_expected.push_back(beat);
			end
		end else begin
			foreach (step_bytes[i]) begin
				beat.out_byte     = step_bytes[i];
				beat.byte_valid   = 1'b1;
				beat.final_result = eot && (i == step_bytes.size() - 1);
				key_expected.push_back(beat);
			end
		end
	endfunction

	task automatic report_mismatch(input string what);
		if (mismatches < 100)
			$display("[%0t] mismatch: %s", $time, what);
		mismatches++;
	endtask

	task automatic check_key_beat(input key_beat_t got);
		key_beat_t want;
		if (key_expected.size() == 0) begin
			report_mismatch($sformatf("unexpected beat byte=%02h valid=%0b last=%0b",
				got.out_byte, got.byte_valid, got.final_result));
		end else begin
			want = key_expected.pop_front();
			if (got.out_byte !== want.out_byte)
				report_mismatch($sformatf("out_byte %02h, want %02h",
					got.out_byte, want.out_byte));
			if (got.byte_valid !== want.byte_valid)
				report_mismatch($sformatf("byte_valid %0b, want %0b",
					got.byte_valid, want.byte_valid));
			if (got.final_result !== want.final_result)
				report_mismatch($sformatf("final_result %0b, want %0b",
					got.final_result, want.final_result));
		end
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (key_ch.valid && key_ch.ready)
				check_key_beat(key_ch.payload);
			if (sink_hold != 0) begin
				sink_hold--;
				key_ch.ready <= 1'b0;
			end else begin
				sink_hold = idle_gap(snk_idling);
				key_ch.ready <= (sink_hold == 0);
				if (sink_hold != 0)
					sink_hold--;
			end
		end
	end

	task automatic send_byte(input logic [7:0] b, input logic eot);
		text_beat_t beat;
		int         gap;
		gap = idle_gap(src_idling);
		if (gap != 0) begin
			text_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		beat.in_byte     = b;
		beat.end_of_text = eot;
		text_ch.valid   <= 1'b1;
		text_ch.payload <= beat;
		do @(posedge clk); while (!text_ch.ready);
		predict_key_bytes(b, eot);
		items_sent++;
	endtask

	task automatic send_text();
		foreach (text_bytes[i])
			send_byte(text_bytes[i], i == text_bytes.size() - 1);
	endtask

	function automatic void append_code(input logic [20:0] cp);
		logic [3:0][7:0] enc;
		int              n;
		n = utf8_encode(cp, enc);
		for (int i = 0; i < n; i++)
			text_bytes.push_back(enc[i]);
	endfunction

	function automatic logic [20:0] pick_code_point();
		int          r;
		logic [20:0] cp;
		r = $urandom_range(0, 99);
		if (r < 25)
			cp = 21'($urandom_range(8'h00, 8'h7F));
		else if (r < 33)
			cp = 21'($urandom_range(CP_UPPER_A, CP_UPPER_Z));
		else if (r < 37)
			cp = $urandom_range(0, 1) ? CP_HYPHEN : CP_APOS;
		else if (r < 45)
			cp = $urandom_range(0, 1) ? 21'($urandom_range(21'h3000, 21'h3003))
			                          : 21'($urandom_range(21'h301B, 21'h301D));
		else if (r < 65)
			cp = 21'($urandom_range(21'h309F, 21'h3100));
		else if (r < 75)
			cp = 21'($urandom_range(21'hFEFF, 21'hFFA0));
		else if (r < 83)
			cp = 21'($urandom_range(21'h80, 21'h7FF));
		else if (r < 93) begin
			cp = 21'($urandom_range(21'h800, 21'hFFFF));
			if (cp >= 21'hD800 && cp <= 21'hDFFF)
				cp = $urandom_range(0, 1) ? CP_REPL : 21'hE000;
		end else
			cp = 21'($urandom_range(21'h10000, 21'h10FFFF));
		return cp;
	endfunction

	function automatic void append_broken();
		logic [3:0][7:0] enc;
		logic [20:0]     cp;
		int              n;
		case ($urandom_range(0, 5))
			0: begin
				cp = 21'($urandom_range(21'h80, 21'h10FFFF));
				if (cp >= 21'hD800 && cp <= 21'hDFFF)
					cp = 21'h3042;
				n = utf8_encode(cp, enc);
				for (int i = 0; i < $urandom_range(1, n - 1); i++)
					text_bytes.push_back(enc[i]);
			end
			1: begin
				case ($urandom_range(0, 3))
					0: begin
						text_bytes.push_back(8'hE0);
						text_bytes.push_back(8'($urandom_range(8'h80, 8'h9F)));
					end
					1: begin
						text_bytes.push_back(8'hED);
						text_bytes.push_back(8'($urandom_range(8'hA0, 8'hBF)));
					end
					2: begin
						text_bytes.push_back(8'hF0);
						text_bytes.push_back(8'($urandom_range(8'h80, 8'h8F)));
					end
					default: begin
						text_bytes.push_back(8'hF4);
						text_bytes.push_back(8'($urandom_range(8'h90, 8'hBF)));
					end
				endcase
			end
			2: text_bytes.push_back(8'($urandom_range(8'h80, 8'hBF)));
			3: begin
				case ($urandom_range(0, 2))
					0: text_bytes.push_back(8'hC0);
					1: text_bytes.push_back(8'hC1);
					default: text_bytes.push_back(8'($urandom_range(8'hF5, 8'hFF)));
				endcase
			end
			4: begin
				text_bytes.push_back(8'hE3);
				text_bytes.push_back(8'h82);
				text_bytes.push_back($urandom_range(0, 1)
					? 8'($urandom_range(8'h00, 8'h7F))
					: 8'($urandom_range(8'hC0, 8'hFF)));
			end
			default: begin
				case ($urandom_range(0, 6))
					0: append_code(21'h80);
					1: append_code(21'h7FF);
					2: append_code(21'h800);
					3: append_code(21'hD7FF);
					4: append_code(21'hFFFF);
					5: append_code(21'h10000);
					default: append_code(21'h10FFFF);
				endcase
			end
		endcase
	endfunction

	task automatic test_ascii_folding();
		text_bytes = '{8'h41, 8'h2D, 8'h27, 8'h00, 8'h5A};
		send_text();
		text_bytes = '{8'h27};
		send_text();
	endtask

	task automatic test_multibyte_folding();
		text_bytes = '{8'hE3, 8'h80, 8'h81, 8'hE3, 8'h82, 8'hA1,
		               8'hF0, 8'h9F, 8'h98, 8'h80};
		send_text();
	endtask

	task automatic test_malformed_input();
		text_bytes = '{8'hFF, 8'h80, 8'hE0, 8'h80, 8'hE3, 8'h41};
		send_text();
		text_bytes = '{8'hF4, 8'h90};
		send_text();
		text_bytes = '{8'hE3, 8'h82};
		send_text();
	endtask

	task automatic test_random_text();
		int kind;
		int nchar;
		src_idling = 1'b0;
		snk_idling = 1'b0;
		while (items_sent < TEXT_ITEMS) begin
			if (items_sent > 180) begin
				src_idling = 1'($urandom_range(0, 1));
				snk_idling = 1'($urandom_range(0, 1));
			end else if (items_sent > 90) begin
				src_idling = 1'b1;
				snk_idling = 1'b1;
			end
			text_bytes.delete();
			kind = $urandom_range(0, 99);
			if (kind < 12) begin
				repeat ($urandom_range(1, 8))
					text_bytes.push_back(8'($urandom_range(0, 255)));
			end else begin
				nchar = $urandom_range(1, 6);
				for (int c = 0; c < nchar; c++)
					if (kind >= 72 && $urandom_range(0, 2) == 0)
						append_broken();
					else
						append_code(pick_code_point());
			end
			send_text();
		end
	endtask

	initial begin
		clk             = 1'b0;
		arst_n          = 1'b0;
		text_ch.valid   = 1'b0;
		text_ch.payload = '0;
		key_ch.ready    = 1'b0;
		dec_cp          = '0;
		dec_left        = '0;
		mismatches      = 0;
		items_sent      = 0;
		sink_hold       = 0;
		src_idling      = 1'b1;
		snk_idling      = 1'b1;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(posedge clk);

		test_ascii_folding();
		test_multibyte_folding();
		test_malformed_input();
		test_random_text();
		text_ch.valid <= 1'b0;

		while (key_expected.size() != 0)
			@(posedge clk);
		repeat (16) @(posedge clk);

		if (mismatches == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
